// ----- hdl/ttcw_pkg.sv -----
// Shared types, constants and helpers for the text terminal character writer.
package ttcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;

   // request tdata layout: char_code, peek_row, peek_col
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_CHAR_LO = 0;
   localparam int REQ_ROW_LO  = REQ_CHAR_LO + CHAR_W;
   localparam int REQ_COL_LO  = REQ_ROW_LO + ROW_W;

   // response tdata layout: cursor_x, cursor_y, cell_char, cell_attr
   localparam int RSP_FIELDS_W = COL_W + ROW_W + CHAR_W + ATTR_W;
   localparam int RSP_TDATA_W  = 32;

   // classified operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_IGNORE  = 3'd0;
   localparam logic [OP_W-1:0] OP_READ    = 3'd1;
   localparam logic [OP_W-1:0] OP_BACK    = 3'd2;
   localparam logic [OP_W-1:0] OP_NEWLINE = 3'd3;
   localparam logic [OP_W-1:0] OP_RETURN  = 3'd4;
   localparam logic [OP_W-1:0] OP_PRINT   = 3'd5;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_US    = 8'd31;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;

   // config registers
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_TEXT_ATTR     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_TOP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_BOTTOM = 2'd2;

   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;
   localparam logic [ROW_W-1:0]  TOP_RESET    = 5'd0;
   localparam logic [ROW_W-1:0]  BOTTOM_RESET = 5'd23;

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CHAR_W-1:0] char_code;
      logic [ADDR_W-1:0] cell_addr;
      logic              in_range;
   } ttcw_item_type;

   typedef struct packed {
      logic [ATTR_W-1:0] cell_attr;
      logic [CHAR_W-1:0] cell_char;
      logic [ROW_W-1:0]  cursor_y;
      logic [COL_W-1:0]  cursor_x;
   } ttcw_result_type;

   function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] r);
      row_base = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS));
   endfunction

   // region rows past the screen clamp to the last row
   function automatic logic [ROW_W-1:0] eff_row(input logic [ROW_W-1:0] r);
      eff_row = (r > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : r;
   endfunction

endpackage

// ----- hdl/ttcw_front.sv -----
// Request decoder: classifies incoming items and forms cell addresses.
module ttcw_front
   import ttcw_pkg::*;
(
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,   // func
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // char_code, peek_row, peek_col
   input  logic                   enable,
   input  logic                   q_full,
   output logic                   q_push,
   output ttcw_item_type          q_item
);

   logic [CHAR_W-1:0] char_code;
   logic [ROW_W-1:0]  peek_row;
   logic [COL_W-1:0]  peek_col;
   logic [OP_W-1:0]   put_op;

   assign char_code = req_tdata[REQ_CHAR_LO +: CHAR_W];
   assign peek_row  = req_tdata[REQ_ROW_LO +: ROW_W];
   assign peek_col  = req_tdata[REQ_COL_LO +: COL_W];

   // controls other than BS, LF/VT/FF and CR are dropped, as is DEL
   always_comb begin
      unique case (char_code) inside
         CH_BS:                                put_op = OP_BACK;
         [CH_LF:CH_FF]:                        put_op = OP_NEWLINE;
         CH_CR:                                put_op = OP_RETURN;
         [8'd0:CH_BS - 8'd1], CH_BS + 8'd1,
         [CH_CR + 8'd1:CH_US], CH_DEL:         put_op = OP_IGNORE;
         default:                              put_op = OP_PRINT;
      endcase
   end

   always_comb begin
      q_item.op        = req_tuser ? OP_READ : put_op;
      q_item.char_code = char_code;
      q_item.cell_addr = row_base(peek_row) + ADDR_W'(peek_col);
      q_item.in_range  = (peek_row < ROW_W'(ROWS)) && (peek_col < COL_W'(COLUMNS));
   end

   assign req_tready = enable & ~q_full;
   assign q_push     = req_tvalid & req_tready;

endmodule

// ----- hdl/ttcw_queue.sv -----
// Short command queue between the decoder and the screen engine.
module ttcw_queue
   import ttcw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ttcw_item_type push_item,
   output logic          full,
   input  logic          pop,
   output ttcw_item_type pop_item,
   output logic          not_empty
);

   ttcw_item_type       slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hdl/ttcw_engine.sv -----
// Screen engine: cursor, config registers, screen memory and scroll sequencer.
module ttcw_engine
   import ttcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  q_valid,
   input  ttcw_item_type         q_item,
   output logic                  q_pop,
   output logic                  ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ttcw_result_type       rsp_result
);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
   localparam logic [ST_W-1:0] ST_READ  = 3'd2;
   localparam logic [ST_W-1:0] ST_COPY  = 3'd3;
   localparam logic [ST_W-1:0] ST_FILL  = 3'd4;
   localparam logic [ST_W-1:0] ST_DONE  = 3'd5;

   logic [CELL_W-1:0] screen_mem [CELLS];

   logic [ST_W-1:0]   state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic              pend_ff, pend_in;
   logic              read_hit_ff, read_hit_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ROW_W-1:0]  bot_ff, bot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ttcw_result_type   rsp_ff, rsp_in;
   logic [CELL_W-1:0] rdata_ff;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [CELL_W-1:0] mem_wdata;

   logic [ROW_W-1:0]  eff_top, eff_bot;
   logic [ADDR_W-1:0] top_base, bot_base;
   logic              scroll_go;

   assign eff_top  = eff_row(top_ff);
   assign eff_bot  = eff_row(bot_ff);
   assign top_base = row_base(eff_top);
   assign bot_base = row_base(eff_bot);

   // config writes
   always_comb begin
      attr_in = attr_ff;
      top_in  = top_ff;
      bot_in  = bot_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_TEXT_ATTR:     attr_in = csr_data[ATTR_W-1:0];
            REG_REGION_TOP:    top_in  = csr_data[ROW_W-1:0];
            REG_REGION_BOTTOM: bot_in  = csr_data[ROW_W-1:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      wr_addr_in   = wr_addr_ff;
      end_in       = end_ff;
      pend_in      = 1'b0;
      read_hit_in  = read_hit_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = addr_ff;
      q_pop        = 1'b0;
      scroll_go    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (addr_ff == ADDR_W'(CELLS - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               read_hit_in = 1'b0;
               state_in    = ST_DONE;
               unique case (q_item.op)
                  OP_READ: begin
                     read_hit_in = q_item.in_range;
                     mem_re      = q_item.in_range;
                     mem_raddr   = q_item.cell_addr;
                     state_in    = ST_READ;
                  end
                  OP_BACK: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                     end
                  end
                  OP_NEWLINE: begin
                     if (row_ff < eff_bot) begin
                        row_in = row_ff + 1'b1;
                     end else begin
                        scroll_go = 1'b1;
                     end
                  end
                  OP_RETURN: begin
                     col_in = '0;
                  end
                  OP_PRINT: begin
                     mem_we    = 1'b1;
                     mem_waddr = row_base(row_ff) + ADDR_W'(col_ff);
                     mem_wdata = {attr_ff, q_item.char_code};
                     if (col_ff == COL_W'(COLUMNS - 1)) begin
                        col_in = '0;
                        if (row_ff >= eff_bot) begin
                           row_in    = eff_bot;
                           scroll_go = 1'b1;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  default: ;
               endcase

               // scroll: copy rows top+1..bottom up one, then blank the bottom row
               if (scroll_go) begin
                  end_in = bot_base + ADDR_W'(COLUMNS - 1);
                  if (eff_top < eff_bot) begin
                     addr_in  = top_base + ADDR_W'(COLUMNS);
                     state_in = ST_COPY;
                  end else begin
                     addr_in  = bot_base;
                     state_in = ST_FILL;
                  end
               end
            end
         end

         ST_READ: begin
            state_in = ST_DONE;
         end

         ST_COPY: begin
            // read one row ahead, write the previous read one row up
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               mem_wdata = rdata_ff;
            end
            if (addr_ff <= end_ff) begin
               mem_re     = 1'b1;
               pend_in    = 1'b1;
               wr_addr_in = addr_ff - ADDR_W'(COLUMNS);
               addr_in    = addr_ff + 1'b1;
            end else if (!pend_ff) begin
               addr_in  = bot_base;
               state_in = ST_FILL;
            end
         end

         ST_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = {attr_ff, CH_SPACE};
            if (addr_ff == end_ff) begin
               state_in = ST_DONE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.cursor_x  = col_ff;
               rsp_in.cursor_y  = row_ff;
               rsp_in.cell_char = read_hit_ff ? rdata_ff[CHAR_W-1:0] : '0;
               rsp_in.cell_attr = read_hit_ff ? rdata_ff[CELL_W-1:CHAR_W] : '0;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         top_ff       <= TOP_RESET;
         bot_ff       <= BOTTOM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         top_ff       <= top_in;
         bot_ff       <= bot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff  <= wr_addr_in;
      end_ff      <= end_in;
      read_hit_ff <= read_hit_in;
      rsp_ff      <= rsp_in;
   end

   // screen memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= screen_mem[mem_raddr];
      end
   end

   assign ready      = (state_ff != ST_CLEAR);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

// ----- hdl/text_terminal_char_writer.sv -----
// Top level of the text terminal character writer.
//
// Text-mode terminal writer over an 80x25 screen of character/attribute cells.
// Each request is either a put (tuser = 0) of one character code or a read
// (tuser = 1) of one cell; every request yields exactly one response carrying
// the cursor after the request and, for reads, the cell contents (zero for
// puts and for reads off the screen). Requests are decoded on entry and queued
// (two deep) for the screen engine, so the request side keeps moving while the
// engine works or a response waits to be taken, until the queue is full. For a
// put or control code that does not scroll, the engine pops and updates, then
// loads the response register; a read adds the registered memory read between
// the two. On an idle block a request is first written into the queue before
// the engine pops it from there. A put or line feed that scrolls copies
// (bottom - top) * 80 cells one per cycle through the screen memory (one write
// port, one registered read port), drains the read pipeline, then blanks the
// 80 cells of the bottom row. After reset the engine clears the 2000-cell
// screen memory, one cell per cycle; req_tready stays low until the clear is
// done. Config writes are taken every cycle (csr_ready is always high) and
// must only be issued while the block is idle.
module text_terminal_char_writer
   import ttcw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,   // [0] func
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] char_code, [12:8] peek_row,
                                               // [19:13] peek_col, [23:20] zero

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [6:0] cursor_x, [11:7] cursor_y,
                                               // [19:12] cell_char, [27:20] cell_attr,
                                               // [31:28] zero

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,   // 0 text_attr, 1 region_top, 2 region_bottom
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   ttcw_item_type   dec_item;
   ttcw_item_type   eng_item;
   ttcw_result_type rsp_result;
   logic            dec_push;
   logic            q_full;
   logic            q_not_empty;
   logic            eng_pop;
   logic            eng_ready;

   // decoder: classify and address each request transfer
   ttcw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .enable     (eng_ready),
      .q_full     (q_full),
      .q_push     (dec_push),
      .q_item     (dec_item)
   );

   // command queue lets the decoder and the engine stall independently
   ttcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (dec_push),
      .push_item (dec_item),
      .full      (q_full),
      .pop       (eng_pop),
      .pop_item  (eng_item),
      .not_empty (q_not_empty)
   );

   // engine: cursor, screen memory, scroll sequencer, response register
   ttcw_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_valid    (q_not_empty),
      .q_item     (eng_item),
      .q_pop      (eng_pop),
      .ready      (eng_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {(RSP_TDATA_W - RSP_FIELDS_W)'(0), rsp_result};

endmodule
